// ----- rtl/hsis_pkg.sv -----
// Shared constants, codes and types of the hash set core.
package hsis_pkg;

  localparam int KEY_W        = 31;
  localparam int BUCKETS_DEF  = 256;
  localparam int WAYS_DEF     = 8;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_SEARCH = 2'd2;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_PRESENT = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  typedef struct packed {
    logic hit;
    logic has_free;
  } match_t;

endpackage

// ----- rtl/hsis_ram.sv -----
// Generic simple dual-port RAM with registered read.
module hsis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/hsis_match.sv -----
// Parallel compare of one bucket row against a key, with lowest-way selection.
module hsis_match #(
  parameter int WAYS = hsis_pkg::WAYS_DEF
) (
  input  logic [WAYS*(hsis_pkg::KEY_W+1)-1:0] row,
  input  logic [hsis_pkg::KEY_W-1:0]          key,
  output hsis_pkg::match_t                    m,
  output logic [WAYS-1:0]                     hit_sel,
  output logic [WAYS-1:0]                     free_sel
);

  localparam int KW = hsis_pkg::KEY_W;

  logic [WAYS-1:0] valid;
  logic [WAYS-1:0] hits;
  logic [WAYS-1:0] frees;

  assign valid = row[WAYS*KW +: WAYS];
  assign frees = ~valid;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      hits[w] = valid[w] && (row[w*KW +: KW] == key);
    end
  end

  // isolate lowest set bit
  assign hit_sel    = hits & (~hits + WAYS'(1));
  assign free_sel   = frees & (~frees + WAYS'(1));
  assign m.hit      = |hits;
  assign m.has_free = |frees;

endmodule

// ----- rtl/hash_set_insert_remove_search_core.sv -----
// Top level of the hash set core: sequencer, bucket memory and write-back.
//
// A set of 31-bit keys held in BUCKETS buckets of WAYS ways. A request is
// taken at a rising edge where start is high and busy is low; its bucket row
// is read from the bucket memory at that edge, compared with the key in the
// next cycle and written back at the end of that cycle, and the result
// (found, status) is shown with done for exactly one cycle after that. A
// request occupies the core through the registered read of the bucket
// memory and the compare and write-back that follow; a new request may be
// taken in the same cycle that done is shown.
// The receiver cannot stall: sample found and status whenever done is high.
// After reset the core clears the bucket memory one row per cycle and holds
// busy high during that pass. BUCKETS must be a power of two; the bucket is
// the key's low bits. Insert of a present key reports already present,
// insert into a full bucket is refused with bucket full, command code 3
// acts as search.
module hash_set_insert_remove_search_core #(
  parameter int BUCKETS = hsis_pkg::BUCKETS_DEF,
  parameter int WAYS    = hsis_pkg::WAYS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 command,
  input  logic [hsis_pkg::KEY_W-1:0] key,
  output logic                       done,
  output logic                       found,
  output logic [1:0]                 status
);

  localparam int KW    = hsis_pkg::KEY_W;
  localparam int IDX_W = $clog2(BUCKETS);
  localparam int ROW_W = WAYS * (KW + 1);

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_LOOK  = 3'b100
  } state_t;

  state_t           state;
  state_t           state_next;
  logic [IDX_W-1:0] clr_addr;
  logic [1:0]       cmd_q;
  logic [KW-1:0]    key_q;

  logic             accept;
  logic             we;
  logic [IDX_W-1:0] waddr;
  logic [ROW_W-1:0] wdata;
  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] new_row;

  hsis_pkg::match_t m;
  logic [WAYS-1:0]  hit_sel;
  logic [WAYS-1:0]  free_sel;

  logic             do_ins;
  logic             do_rem;
  logic [1:0]       status_next;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  // Bucket memory: one row per bucket, valid bits on top, keys below.
  hsis_ram #(
    .WIDTH (ROW_W),
    .DEPTH (BUCKETS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (accept),
    .raddr (key[IDX_W-1:0]),
    .rdata (rd_row)
  );

  hsis_match #(
    .WAYS (WAYS)
  ) u_match (
    .row      (rd_row),
    .key      (key_q),
    .m        (m),
    .hit_sel  (hit_sel),
    .free_sel (free_sel)
  );

  // Decode the held request and pick the status code.
  always_comb begin
    do_ins      = 1'b0;
    do_rem      = 1'b0;
    status_next = hsis_pkg::ST_ABSENT;
    case (cmd_q)
      hsis_pkg::CMD_INSERT: begin
        if (m.hit) begin
          status_next = hsis_pkg::ST_PRESENT;
        end else if (m.has_free) begin
          do_ins      = 1'b1;
          status_next = hsis_pkg::ST_DONE;
        end else begin
          status_next = hsis_pkg::ST_FULL;
        end
      end
      hsis_pkg::CMD_REMOVE: begin
        do_rem      = m.hit;
        status_next = m.hit ? hsis_pkg::ST_DONE : hsis_pkg::ST_ABSENT;
      end
      default: begin
        // search, and the unused code acts the same
        status_next = m.hit ? hsis_pkg::ST_DONE : hsis_pkg::ST_ABSENT;
      end
    endcase
  end

  // Build the modified row: set or drop one valid bit, drop the key in.
  always_comb begin
    new_row = rd_row;
    for (int w = 0; w < WAYS; w++) begin
      if (do_ins && free_sel[w]) begin
        new_row[w*KW +: KW]   = key_q;
        new_row[WAYS*KW + w]  = 1'b1;
      end
      if (do_rem && hit_sel[w]) begin
        new_row[WAYS*KW + w]  = 1'b0;
      end
    end
  end

  // Write port: clearing pass after reset, else write-back of a changed row.
  always_comb begin
    if (state == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else begin
      we    = (state == S_LOOK) && (do_ins || do_rem);
      waddr = key_q[IDX_W-1:0];
      wdata = new_row;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == IDX_W'(BUCKETS - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_next = S_LOOK;
        end
      end
      S_LOOK:  state_next = S_IDLE;
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clr_addr <= clr_addr + IDX_W'(1);
      end
      done <= (state == S_LOOK);
    end
  end

  // Payload registers: hold the request, capture the result.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= command;
      key_q <= key;
    end
    if (state == S_LOOK) begin
      found  <= m.hit;
      status <= status_next;
    end
  end

endmodule

// ----- rtl/hsis_checker.sv -----
// Port-level checker of the hash set core, bound to the top level.
module hsis_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       found,
  input logic [1:0] status
);

  // an accepted request holds the core busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("core not busy after accepting a request");

  // every accepted request is answered with done after the core has passed through S_LOOK
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> ##1 done)
    else $error("no result two cycles after request");

  // results never come in back-to-back cycles
  a_done_gap: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("results in consecutive cycles");

  // a result only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in progress");

  // a present key never reports absent or bucket full
  a_found_status: assert property (@(posedge clk) disable iff (rst)
    done && found |-> status == hsis_pkg::ST_DONE || status == hsis_pkg::ST_PRESENT)
    else $error("found with inconsistent status");

endmodule

bind hash_set_insert_remove_search_core hsis_checker u_hsis_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .found  (found),
  .status (status)
);
